// ===== design/assert_macros.svh =====
// Assertion helpers used by sorted_timer_queue_top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// stq_pkg
// Shared constants and codes of the sorted timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int unsigned DefDepth     = 16;
  localparam int unsigned DefTimeWidth = 32;
  localparam int unsigned IdWidth      = 4;

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TICK   = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    RK_SET    = 2'd0,
    RK_REMOVE = 2'd1,
    RK_EXPIRE = 2'd2
  } result_kind_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [IdWidth-1:0] id;
    logic               found;
    logic               full;
    logic               last;
  } result_t;

endpackage

// ===== design/sorted_timer_queue_top.sv =====
// Set compares entries from the tail, moving each later one up a slot, then writes the new
// entry; remove answers at once from the ID map when the ID is free, else scans and shifts;
// tick pops due entries from the head, and an empty or not-due tick ends without a result.
// Throughput: one request at a time; the entry memory (one read and one write port,
// registered read data) sets the pace of every insert, delete and expiry scan.
// Reset: asynchronous, active low; clears the count, head and ID map, the memory keeps data.
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// sorted_timer_queue_top
// Timer table sorted by finish time, kept as a ring in one synchronous memory.
// ----------------------------------------------------------------------------
module sorted_timer_queue_top #(
  parameter int unsigned DEPTH      = stq_pkg::DefDepth,
  parameter int unsigned TIME_WIDTH = stq_pkg::DefTimeWidth,
  localparam int unsigned InW = ((TIME_WIDTH + stq_pkg::IdWidth + 7) / 8) * 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  output logic           s_tready_o,
  input  logic [InW-1:0] s_tdata_i,   // time_value, timer_id, zero pad
  input  logic [1:0]     s_tuser_i,   // opcode
  output logic           m_tvalid_o,
  input  logic           m_tready_i,
  output logic [7:0]     m_tdata_o,   // result_id, found, full_res, zero pad
  output logic [1:0]     m_tuser_o,   // result_kind
  output logic           m_tlast_o
);

  localparam int unsigned AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned IdW = stq_pkg::IdWidth;

  typedef struct packed {
    logic [TIME_WIDTH-1:0] tm;
    logic [AW-1:0]         id;
  } entry_t;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_INS_RD  = 9'b000000010,
    S_INS_CMP = 9'b000000100,
    S_INS_WR  = 9'b000001000,
    S_RM_RD   = 9'b000010000,
    S_RM_CMP  = 9'b000100000,
    S_TK_RD   = 9'b001000000,
    S_TK_CMP  = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d, idx_q, idx_d;
  logic [AW-1:0] head_q, head_d;
  logic [DEPTH-1:0] free_q, free_d;
  logic shift_q, shift_d, have_q, have_d;
  logic [TIME_WIDTH-1:0] t_q, t_d;
  logic [IdW-1:0] rid_q, rid_d;
  logic [AW-1:0] nid_q, nid_d, cand_q, cand_d;
  stq_pkg::result_t res_q, res_d, out_q, out_d;
  logic out_valid_q, out_valid_d;

  entry_t mem [DEPTH];
  entry_t rdata_q;
  logic rd_en, wr_en;
  logic [AW-1:0] raddr, waddr;
  entry_t wdata;

  logic [TIME_WIDTH-1:0] in_time;
  logic [IdW-1:0] in_id;
  logic [AW-1:0] low_free;
  logic any_free, out_free, rid_ok, accept;

  assign in_time = s_tdata_i[TIME_WIDTH-1:0];
  assign in_id   = s_tdata_i[TIME_WIDTH +: IdW];
  assign s_tready_o = (state_q == S_IDLE);
  assign accept = s_tvalid_i && s_tready_o;
  assign out_free = !out_valid_q || m_tready_i;
  assign rid_ok = ({{(AW+IdW){1'b0}}, rid_q} < (AW+2*IdW)'(DEPTH));

  // Ring position of a logical slot.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [CW-1:0] l);
    logic [AW:0] sum;
    sum = {1'b0, hd} + (AW+1)'(l);
    if (sum >= (AW+1)'(DEPTH)) sum = sum - (AW+1)'(DEPTH);
    return sum[AW-1:0];
  endfunction

  always_comb begin
    low_free = '0;
    any_free = 1'b0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (free_q[i]) begin
        low_free = AW'(i);
        any_free = 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d = idx_q;
    head_d = head_q;
    free_d = free_q;
    shift_d = shift_q;
    have_d = have_q;
    t_d = t_q;
    rid_d = rid_q;
    nid_d = nid_q;
    cand_d = cand_q;
    res_d = res_q;
    out_d = out_q;
    out_valid_d = out_valid_q && !m_tready_i;
    rd_en = 1'b0;
    wr_en = 1'b0;
    raddr = '0;
    waddr = '0;
    wdata = rdata_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          t_d = in_time;
          rid_d = in_id;
          nid_d = low_free;
          idx_d = count_q;
          shift_d = 1'b0;
          have_d = 1'b0;
          unique case (s_tuser_i)
            stq_pkg::OP_SET: begin
              if (count_q >= CW'(DEPTH) || !any_free) begin
                res_d = '{kind: stq_pkg::RK_SET, id: '0, found: 1'b0, full: 1'b1,
                          last: 1'b1};
                state_d = S_DONE;
              end else if (count_q == '0) begin
                state_d = S_INS_WR;
              end else begin
                state_d = S_INS_RD;
              end
            end
            stq_pkg::OP_REMOVE: begin
              idx_d = '0;
              state_d = S_RM_RD;
            end
            stq_pkg::OP_TICK: begin
              if (count_q != '0) state_d = S_TK_RD;
            end
            default: ;
          endcase
        end
      end
      S_INS_RD: begin
        rd_en = 1'b1;
        raddr = phys(head_q, idx_q - CW'(1));
        state_d = S_INS_CMP;
      end
      S_INS_CMP: begin
        if (rdata_q.tm >= t_q) begin
          wr_en = 1'b1;
          waddr = phys(head_q, idx_q);
          idx_d = idx_q - CW'(1);
          state_d = (idx_q == CW'(1)) ? S_INS_WR : S_INS_RD;
        end else begin
          state_d = S_INS_WR;
        end
      end
      S_INS_WR: begin
        wr_en = 1'b1;
        waddr = phys(head_q, idx_q);
        wdata = '{tm: t_q, id: nid_q};
        count_d = count_q + CW'(1);
        free_d[nid_q] = 1'b0;
        res_d = '{kind: stq_pkg::RK_SET, id: IdW'(nid_q), found: 1'b0, full: 1'b0,
                  last: 1'b1};
        state_d = S_DONE;
      end
      S_RM_RD: begin
        // The ID map tells at once whether the scan can succeed.
        if (!shift_q && (!rid_ok || free_q[AW'(rid_q)])) begin
          res_d = '{kind: stq_pkg::RK_REMOVE, id: rid_q, found: 1'b0, full: 1'b0,
                    last: 1'b1};
          state_d = S_DONE;
        end else begin
          rd_en = 1'b1;
          raddr = phys(head_q, shift_q ? idx_q + CW'(1) : idx_q);
          state_d = S_RM_CMP;
        end
      end
      S_RM_CMP: begin
        if (shift_q) begin
          wr_en = 1'b1;
          waddr = phys(head_q, idx_q);
          idx_d = idx_q + CW'(1);
        end
        if (shift_q || rdata_q.id == AW'(rid_q)) begin
          shift_d = 1'b1;
          if ((shift_q ? idx_q + CW'(2) : idx_q + CW'(1)) == count_q) begin
            count_d = count_q - CW'(1);
            free_d[AW'(rid_q)] = 1'b1;
            res_d = '{kind: stq_pkg::RK_REMOVE, id: rid_q, found: 1'b1, full: 1'b0,
                      last: 1'b1};
            state_d = S_DONE;
          end else begin
            state_d = S_RM_RD;
          end
        end else begin
          idx_d = idx_q + CW'(1);
          state_d = S_RM_RD;
        end
      end
      S_TK_RD: begin
        rd_en = 1'b1;
        raddr = head_q;
        state_d = S_TK_CMP;
      end
      S_TK_CMP: begin
        if (rdata_q.tm <= t_q) begin
          // A due entry releases the one held back, which was not the last.
          if (!have_q || out_free) begin
            if (have_q) begin
              out_d = '{kind: stq_pkg::RK_EXPIRE, id: IdW'(cand_q), found: 1'b0,
                        full: 1'b0, last: 1'b0};
              out_valid_d = 1'b1;
            end
            cand_d = rdata_q.id;
            have_d = 1'b1;
            head_d = phys(head_q, CW'(1));
            count_d = count_q - CW'(1);
            free_d[rdata_q.id] = 1'b1;
            if (count_q == CW'(1)) begin
              res_d = '{kind: stq_pkg::RK_EXPIRE, id: IdW'(rdata_q.id), found: 1'b0,
                        full: 1'b0, last: 1'b1};
              state_d = S_DONE;
            end else begin
              state_d = S_TK_RD;
            end
          end
        end else if (have_q) begin
          res_d = '{kind: stq_pkg::RK_EXPIRE, id: IdW'(cand_q), found: 1'b0,
                    full: 1'b0, last: 1'b1};
          state_d = S_DONE;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_d = res_q;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Reads and writes never touch the same entry in back-to-back cycles, so no
  // forwarding is needed.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[waddr] <= wdata;
    if (rd_en) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      head_q <= '0;
      free_q <= '1;
      out_valid_q <= 1'b0;
      shift_q <= 1'b0;
      have_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      head_q <= head_d;
      free_q <= free_d;
      out_valid_q <= out_valid_d;
      shift_q <= shift_d;
      have_q <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    t_q <= t_d;
    rid_q <= rid_d;
    nid_q <= nid_d;
    cand_q <= cand_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o = out_q.kind;
  assign m_tdata_o = {2'b00, out_q.full, out_q.found, out_q.id};
  assign m_tlast_o = out_q.last;

  `ASSERT_RST(a_count_bound, clk_i, rst_ni, count_q <= CW'(DEPTH), "count exceeds depth")
  `ASSERT_RST(a_ids_balance, clk_i, rst_ni, ($countones(free_q) + count_q) == DEPTH, "ID map and count disagree")
  `ASSERT_RST(a_req_starts, clk_i, rst_ni, (accept && (s_tuser_i == stq_pkg::OP_SET || s_tuser_i == stq_pkg::OP_REMOVE)) |=> (state_q != S_IDLE), "request not started")

endmodule

// ===== tb/tb_sorted_timer_queue_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_timer_queue_top
// Drives set, remove and tick requests into the timer queue, predicts every
// result with a behavioral copy of the sorted table, and compares results in
// order under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_sorted_timer_queue_top;

  localparam int unsigned Depth   = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned InW     = ((TimeW + stq_pkg::IdWidth + 7) / 8) * 8;
  localparam int unsigned Watchdog = 20000;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] id;
    logic       found;
    logic       full;
    logic       last;
  } expiry_t;

  typedef struct {
    stq_pkg::opcode_e op;
    logic [31:0]      tval;
    logic [3:0]       tid;
    bit               typed;
    expiry_t          res;
  } req_row_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           s_tvalid_i = 1'b0;
  logic           s_tready_o;
  logic [InW-1:0] s_tdata_i = '0;
  logic [1:0]     s_tuser_i = '0;
  logic           m_tvalid_o;
  logic           m_tready_i = 1'b0;
  logic [7:0]     m_tdata_o;
  logic [1:0]     m_tuser_o;
  logic           m_tlast_o;

  sorted_timer_queue_top dut (.*);

  always #5 clk_i = ~clk_i;

  // Shadow of the sorted table.
  logic [31:0] sh_finish [Depth];
  logic [3:0]  sh_id [Depth];
  int unsigned sh_count;
  logic [15:0] sh_free;

  expiry_t pending_results[$];
  int      fail_count;
  int      send_idle_pct;
  int      recv_idle_pct;
  int      quiet_cycles;

  task automatic report_mismatch(input string what, input expiry_t got, input expiry_t want);
    $display("mismatch %s: got kind %0d id %0d found %0b full %0b last %0b, ",
             what, got.kind, got.id, got.found, got.full, got.last,
             "want kind %0d id %0d found %0b full %0b last %0b",
             want.kind, want.id, want.found, want.full, want.last);
    fail_count++;
  endtask

  function automatic expiry_t mk(stq_pkg::result_kind_e k, logic [3:0] id, logic f, logic fl,
                                 logic l);
    expiry_t r;
    r.kind = k; r.id = id; r.found = f; r.full = fl; r.last = l;
    return r;
  endfunction

  // Applies one request to the shadow table and queues its results.
  task automatic predict_queue(input stq_pkg::opcode_e op, input logic [31:0] t,
                               input logic [3:0] rid);
    int unsigned pos, n, nid;
    nid = Depth;
    if (op == stq_pkg::OP_SET) begin
      for (int i = Depth - 1; i >= 0; i--) if (sh_free[i]) nid = i;
      if (sh_count >= Depth || nid >= Depth) begin
        pending_results.push_back(mk(stq_pkg::RK_SET, 4'd0, 1'b0, 1'b1, 1'b1));
      end else begin
        pos = 0;
        while (pos < sh_count && sh_finish[pos] < t) pos++;
        for (int i = sh_count; i > pos; i--) begin
          sh_finish[i] = sh_finish[i-1];
          sh_id[i] = sh_id[i-1];
        end
        sh_finish[pos] = t;
        sh_id[pos] = nid[3:0];
        sh_count++;
        sh_free[nid] = 1'b0;
        pending_results.push_back(mk(stq_pkg::RK_SET, nid[3:0], 1'b0, 1'b0, 1'b1));
      end
    end else if (op == stq_pkg::OP_REMOVE) begin
      pos = 0;
      while (pos < sh_count && sh_id[pos] != rid) pos++;
      if (pos >= sh_count) begin
        pending_results.push_back(mk(stq_pkg::RK_REMOVE, rid, 1'b0, 1'b0, 1'b1));
      end else begin
        for (int i = pos; i + 1 < sh_count; i++) begin
          sh_finish[i] = sh_finish[i+1];
          sh_id[i] = sh_id[i+1];
        end
        sh_count--;
        sh_free[rid] = 1'b1;
        pending_results.push_back(mk(stq_pkg::RK_REMOVE, rid, 1'b1, 1'b0, 1'b1));
      end
    end else if (op == stq_pkg::OP_TICK) begin
      n = 0;
      while (n < sh_count && sh_finish[n] <= t) n++;
      for (int i = 0; i < n; i++) begin
        pending_results.push_back(mk(stq_pkg::RK_EXPIRE, sh_id[i], 1'b0, 1'b0, (i + 1 == n)));
        sh_free[sh_id[i]] = 1'b1;
      end
      for (int i = 0; i + n < sh_count; i++) begin
        sh_finish[i] = sh_finish[i+n];
        sh_id[i] = sh_id[i+n];
      end
      sh_count -= n;
    end
  endtask

  // Valid stays high after an accepted request until the next one replaces it
  // or an idle cycle drops it.
  task automatic send_request(input logic [1:0] op, input logic [31:0] t, input logic [3:0] rid);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= op;
    s_tdata_i  <= {{(InW - TimeW - 4){1'b0}}, rid, t};
    do @(posedge clk_i); while (!s_tready_o);
    if (op <= stq_pkg::OP_TICK) predict_queue(stq_pkg::opcode_e'(op), t, rid);
  endtask

  // Result side: random stalls and in-order comparison.
  always @(posedge clk_i) begin
    expiry_t got;
    if (rst_ni) begin
      if (m_tvalid_o && m_tready_i) begin
        got = {m_tuser_o, m_tdata_o[3:0], m_tdata_o[4], m_tdata_o[5], m_tlast_o};
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", got, '0);
        end else begin
          if (got != pending_results[0]) report_mismatch("field", got, pending_results[0]);
          pending_results.delete(0);
        end
      end
      m_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= Watchdog) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] rand_time(input int unsigned bias);
    case ($urandom_range(7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      default: return 32'(bias + $urandom_range(200));
    endcase
  endfunction

  task automatic random_phase(input int count, input int sidle, input int ridle);
    int unsigned base;
    logic [1:0] op;
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    base = 1000;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: op = stq_pkg::OP_SET;
        5, 6:          op = stq_pkg::OP_REMOVE;
        7, 8:          op = stq_pkg::OP_TICK;
        default:       op = 2'd3;
      endcase
      if (op == stq_pkg::OP_TICK) base += $urandom_range(60);
      send_request(op,
                   (op == stq_pkg::OP_TICK) ? 32'(base + $urandom_range(40)) : rand_time(base),
                   4'($urandom_range(15)));
    end
  endtask

  task automatic drain();
    s_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  req_row_t directed_rows[$];

  initial begin
    req_row_t row;
    fail_count = 0;
    quiet_cycles = 0;
    sh_count = 0;
    sh_free = '1;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: empty removes and ticks, extremes, ties, full table, unused opcode.
    directed_rows.push_back('{stq_pkg::OP_REMOVE, 32'd0, 4'd15, 1'b1,
                              mk(stq_pkg::RK_REMOVE, 4'd15, 1'b0, 1'b0, 1'b1)});
    directed_rows.push_back('{stq_pkg::OP_TICK, 32'hFFFF_FFFF, 4'd0, 1'b0, '0});
    directed_rows.push_back('{stq_pkg::OP_SET, 32'hFFFF_FFFF, 4'd0, 1'b1,
                              mk(stq_pkg::RK_SET, 4'd0, 1'b0, 1'b0, 1'b1)});
    directed_rows.push_back('{stq_pkg::OP_SET, 32'd0, 4'd0, 1'b1,
                              mk(stq_pkg::RK_SET, 4'd1, 1'b0, 1'b0, 1'b1)});
    directed_rows.push_back('{stq_pkg::OP_SET, 32'd0, 4'd0, 1'b0, '0});
    for (int i = 0; i < 13; i++)
      directed_rows.push_back('{stq_pkg::OP_SET, 32'h5555_AAAA + 32'(i), 4'd0, 1'b0, '0});
    directed_rows.push_back('{stq_pkg::OP_SET, 32'd7, 4'd0, 1'b1,
                              mk(stq_pkg::RK_SET, 4'd0, 1'b0, 1'b1, 1'b1)});
    directed_rows.push_back('{stq_pkg::opcode_e'(2'd3), 32'hFFFF_FFFF, 4'd15, 1'b0, '0});
    directed_rows.push_back('{stq_pkg::OP_REMOVE, 32'hFFFF_FFFF, 4'd1, 1'b0, '0});
    directed_rows.push_back('{stq_pkg::OP_TICK, 32'h5555_AAB0, 4'd0, 1'b0, '0});
    directed_rows.push_back('{stq_pkg::OP_REMOVE, 32'd0, 4'd0, 1'b0, '0});
    directed_rows.push_back('{stq_pkg::OP_TICK, 32'hFFFF_FFFF, 4'd15, 1'b0, '0});

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      send_request(row.op, row.tval, row.tid);
      // Typed rows also confirm the shadow itself.
      if (row.typed && pending_results[$] != row.res)
        report_mismatch("directed row", pending_results[$], row.res);
    end
    drain();

    random_phase(140, 15, 47);
    drain();
    random_phase(140, 47, 15);
    drain();
    random_phase(130, 0, 0);
    drain();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sorted_timer_queue_top.f =====
+incdir+design
design/stq_pkg.sv
design/sorted_timer_queue_top.sv
tb/tb_sorted_timer_queue_top.sv
